/* design/ecd_pkg.sv */
// Shared types, constants and small tables for the epoch-seconds to UTC date unit.
`default_nettype none

package ecd_pkg;

  // Days in one 400-year Gregorian cycle
  localparam int DAYS_PER_CYCLE = (365 * 400) + 100 - 4 + 1;

  // Remainder width of the shared divider; holds any divisor below
  localparam int REM_W = 18;

  // Divider digit, partial dividend and reciprocal widths
  localparam int DIG_W = 8;
  localparam int NUM_W = REM_W + DIG_W;
  localparam int RCP_W = 24;

  localparam int YEAR_W = 24;
  localparam int OUT_W  = 64;

  // Year 1970 within its 400-year cycle
  localparam logic [8:0] EPOCH_Y400 = 9'd370;
  localparam logic [8:0] LAST_Y400  = 9'd399;
  localparam logic [3:0] LAST_MONTH = 4'd11;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_7,
    DIV_CYCLE
  } div_sel_t;

  typedef struct packed {
    logic     start;
    div_sel_t sel;
  } div_ctl_t;

  function automatic logic [REM_W-1:0] div_const(input div_sel_t sel);
    logic [REM_W-1:0] d;
    unique case (sel)
      DIV_60:    d = REM_W'(60);
      DIV_24:    d = REM_W'(24);
      DIV_7:     d = REM_W'(7);
      DIV_CYCLE: d = REM_W'(DAYS_PER_CYCLE);
    endcase
    return d;
  endfunction

  // floor(2^NUM_W / d); the estimate it gives is low by at most one
  function automatic logic [RCP_W-1:0] div_recip(input div_sel_t sel);
    logic [RCP_W-1:0] m;
    unique case (sel)
      DIV_60:    m = RCP_W'((1 << NUM_W) / 60);
      DIV_24:    m = RCP_W'((1 << NUM_W) / 24);
      DIV_7:     m = RCP_W'((1 << NUM_W) / 7);
      DIV_CYCLE: m = RCP_W'((1 << NUM_W) / DAYS_PER_CYCLE);
    endcase
    return m;
  endfunction

  // Leap rule on the year position within the 400-year cycle
  function automatic logic is_leap(input logic [8:0] y400);
    return (y400[1:0] == 2'd0) && (y400 != 9'd100) && (y400 != 9'd200) &&
           (y400 != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    unique case (mon)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* design/ecd_div.sv */
// Shared constant divider: 8-bit quotient digits by reciprocal multiply, subtract and fix.
`default_nettype none

module ecd_div
  import ecd_pkg::*;
#(
  parameter int WIDTH = 48
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire div_ctl_t                     ctl,
  input  wire logic [WIDTH-1:0]             arg,
  output logic      [WIDTH-1:0]             quot,
  output logic      [REM_W-1:0]             rem,
  output logic                              done
);

  localparam int DIG_N  = (WIDTH + DIG_W - 1) / DIG_W;
  localparam int ACC_W  = DIG_N * DIG_W;
  localparam int CNT_W  = $clog2(DIG_N);
  localparam int PROD_W = NUM_W + RCP_W;

  localparam logic [1:0] PH_MUL = 2'd0;
  localparam logic [1:0] PH_SUB = 2'd1;
  localparam logic [1:0] PH_FIX = 2'd2;

  logic [ACC_W-1:0]  acc;
  logic [REM_W-1:0]  part;
  logic [REM_W-1:0]  divisor;
  logic [RCP_W-1:0]  recip;
  logic [DIG_W-1:0]  qdig;
  logic [NUM_W-1:0]  trial;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        phase;
  logic              busy;

  logic [NUM_W-1:0]  num_now;
  logic [PROD_W-1:0] prod;
  logic              last_step;

  // partial remainder with the next dividend digit below it
  assign num_now   = {part, acc[ACC_W-1 -: DIG_W]};
  assign prod      = PROD_W'(num_now) * PROD_W'(recip);
  assign last_step = busy && (phase == PH_FIX) && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_MUL;
    end else begin
      done <= last_step;
      busy <= ctl.start | (busy & ~last_step);
      if (ctl.start || phase == PH_FIX) begin
        phase <= PH_MUL;
      end else if (busy) begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc     <= ACC_W'(arg);
      part    <= '0;
      divisor <= div_const(ctl.sel);
      recip   <= div_recip(ctl.sel);
      cnt     <= CNT_W'(DIG_N - 1);
    end else if (busy) begin
      unique case (phase)
        PH_MUL: begin
          qdig <= prod[NUM_W +: DIG_W];
        end
        PH_SUB: begin
          trial <= num_now - NUM_W'(qdig) * NUM_W'(divisor);
        end
        PH_FIX: begin
          // estimate may be one short
          if (trial >= NUM_W'(divisor)) begin
            acc  <= {acc[ACC_W-DIG_W-1:0], qdig + DIG_W'(1)};
            part <= REM_W'(trial - NUM_W'(divisor));
          end else begin
            acc  <= {acc[ACC_W-DIG_W-1:0], qdig};
            part <= trial[REM_W-1:0];
          end
          cnt <= cnt - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign quot = acc[WIDTH-1:0];
  assign rem  = part;

endmodule

`default_nettype wire

/* design/epoch_seconds_to_utc_date_unit.sv */
// Top level: epoch seconds to broken-down UTC calendar date.
//
// Input stream s_*: one request per item, tdata holds the signed seconds count
// since 1970-01-01 00:00:00 UTC in its low SECONDS_WIDTH bits.
// Output stream m_*: one date per request, fields packed as listed at m_tdata.
// Negative counts borrow downward, so every field stays in range.
//
// A request goes through five passes of one shared constant divider (by 60,
// 60, 24, 7 and the 146097-day cycle), then a year walk and a month walk over
// the remainder. The divider makes each 8-bit quotient digit in a multiply,
// a subtract and a fix phase. The year walk steps one year at a time and the
// month walk one month at a time. When the month walk ends and the output
// register is free, m_tvalid rises together with s_tready.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register; the next request is taken while it waits. If the receiver
// still holds the previous result when a new one finishes, the sequencer
// holds until m_tready. Reset empties the output register and returns idle.
`default_nettype none

module epoch_seconds_to_utc_date_unit
  import ecd_pkg::*;
#(
  parameter int SECONDS_WIDTH = 48
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [((SECONDS_WIDTH+7)/8)*8-1:0]    s_tdata,  // epoch_seconds
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // second, minute, hour, week_day, month_day, month, year_day,
  // years_since_1900, zero fill
  output logic      [OUT_W-1:0]                      m_tdata
);

  localparam int W      = SECONDS_WIDTH;
  localparam int CW     = W - 32;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SEC   = 4'd1;
  localparam logic [3:0] ST_MIN   = 4'd2;
  localparam logic [3:0] ST_HOUR  = 4'd3;
  localparam logic [3:0] ST_WEEK  = 4'd4;
  localparam logic [3:0] ST_CYC   = 4'd5;
  localparam logic [3:0] ST_YEAR  = 4'd6;
  localparam logic [3:0] ST_MONTH = 4'd7;

  logic [3:0]              state;
  logic                    neg;
  logic [W-1:0]            days;
  logic [5:0]              sec;
  logic [5:0]              min;
  logic [4:0]              hour;
  logic [2:0]              wday;
  logic signed [CW-1:0]    cyc;
  logic [REM_W-1:0]        rem;
  logic [8:0]              walk;
  logic [8:0]              y400;
  logic [8:0]              yday;
  logic [3:0]              mon;

  div_ctl_t                div_ctl;
  logic [W-1:0]            div_arg;
  logic [W-1:0]            div_quot;
  logic [REM_W-1:0]        div_rem;
  logic                    div_done;

  logic [W-1:0]            mag;
  logic [2:0]              dm7;
  logic                    leap;
  logic [8:0]              year_len;
  logic [4:0]              mlen;
  logic                    out_free;
  logic                    result_load;
  logic signed [YEAR_W-1:0] cyc_ext;
  logic [YEAR_W-1:0]       years;

  ecd_div #(.WIDTH(W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .arg  (div_arg),
    .quot (div_quot),
    .rem  (div_rem),
    .done (div_done)
  );

  // negative counts run through the divider as their complement
  assign mag = s_tdata[W-1] ? ~s_tdata[W-1:0] : s_tdata[W-1:0];

  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.sel   = DIV_60;
    div_arg       = '0;
    unique case (state)
      ST_IDLE: begin
        div_ctl.start = s_tvalid;
        div_arg       = mag;
      end
      ST_SEC: begin
        div_ctl.start = div_done;
        div_arg       = div_quot;
      end
      ST_MIN: begin
        div_ctl.start = div_done;
        div_ctl.sel   = DIV_24;
        div_arg       = div_quot;
      end
      ST_HOUR: begin
        div_ctl.start = div_done;
        div_ctl.sel   = DIV_7;
        div_arg       = div_quot;
      end
      ST_WEEK: begin
        div_ctl.start = div_done;
        div_ctl.sel   = DIV_CYCLE;
        div_arg       = days;
      end
      default: begin
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign out_free = ~m_tvalid | m_tready;

  assign dm7      = neg ? (3'd6 - div_rem[2:0]) : div_rem[2:0];
  assign leap     = is_leap(y400);
  assign year_len = 9'd365 + {8'd0, leap};
  assign mlen     = month_len(leap, mon);

  assign result_load = (state == ST_MONTH) &&
                       !(mon < LAST_MONTH && rem >= {13'd0, mlen}) && out_free;

  assign cyc_ext  = YEAR_W'(cyc);
  assign years    = YEAR_W'(70) + (cyc_ext <<< 8) + (cyc_ext <<< 7) + (cyc_ext <<< 4) +
                    YEAR_W'(walk);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= result_load | (m_tvalid & ~m_tready);
      unique case (state)
        ST_IDLE:  if (s_tvalid) state <= ST_SEC;
        ST_SEC:   if (div_done) state <= ST_MIN;
        ST_MIN:   if (div_done) state <= ST_HOUR;
        ST_HOUR:  if (div_done) state <= ST_WEEK;
        ST_WEEK:  if (div_done) state <= ST_CYC;
        ST_CYC:   if (div_done) state <= ST_YEAR;
        ST_YEAR:  if (rem < {9'd0, year_len}) state <= ST_MONTH;
        ST_MONTH: if (result_load) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) neg <= s_tdata[W-1];
      end
      ST_SEC: begin
        if (div_done) sec <= neg ? (6'd59 - div_rem[5:0]) : div_rem[5:0];
      end
      ST_MIN: begin
        if (div_done) min <= neg ? (6'd59 - div_rem[5:0]) : div_rem[5:0];
      end
      ST_HOUR: begin
        if (div_done) begin
          hour <= neg ? (5'd23 - div_rem[4:0]) : div_rem[4:0];
          days <= div_quot;
        end
      end
      ST_WEEK: begin
        // epoch day was a Thursday
        if (div_done) wday <= (dm7 >= 3'd3) ? (dm7 - 3'd3) : (dm7 + 3'd4);
      end
      ST_CYC: begin
        if (div_done) begin
          cyc  <= neg ? ~div_quot[CW-1:0] : div_quot[CW-1:0];
          rem  <= neg ? (REM_W'(DAYS_PER_CYCLE - 1) - div_rem) : div_rem;
          walk <= '0;
          y400 <= EPOCH_Y400;
        end
      end
      ST_YEAR: begin
        if (rem >= {9'd0, year_len}) begin
          rem  <= rem - {9'd0, year_len};
          walk <= walk + 9'd1;
          y400 <= (y400 == LAST_Y400) ? 9'd0 : (y400 + 9'd1);
        end else begin
          yday <= rem[8:0];
          mon  <= '0;
        end
      end
      ST_MONTH: begin
        if (mon < LAST_MONTH && rem >= {13'd0, mlen}) begin
          rem <= rem - {13'd0, mlen};
          mon <= mon + 4'd1;
        end else if (out_free) begin
          m_tdata <= {2'b00, years, yday, mon, rem[4:0] + 5'd1, wday, hour, min, sec};
        end
      end
      default: begin
      end
    endcase
  end

  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_SEC || state == ST_MIN || state == ST_HOUR ||
                  state == ST_WEEK || state == ST_CYC))
    else $error("divider finished outside a division pass");

  a_cycle_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_YEAR) |-> (rem < REM_W'(DAYS_PER_CYCLE) && walk < 9'd400 &&
                            y400 < 9'd400))
    else $error("year walk out of the 400-year cycle");

  a_month_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MONTH) |-> (rem < REM_W'(366) && mon <= LAST_MONTH))
    else $error("month walk remainder out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
